// File: hw/rtl/cfb_pkg.sv
// Package for the chunked frame builder: sizes, opcodes, FSM states and the
// request, response and cell-control structs. Depends on nothing.
`default_nettype none

package cfb_pkg;

  // Frame size in bytes, header included (2 to 64).
  localparam int unsigned FrameBytes = 64;
  localparam int unsigned StoreDepth = FrameBytes - 1;
  localparam int unsigned CountW     = $clog2(FrameBytes);

  // Header layout: bit 7 final, bit 6 delimiter, bits 5..0 length/value.
  localparam int unsigned HdrLenW    = 6;
  localparam int unsigned HdrFinalB  = 7;
  localparam int unsigned HdrDelimB  = 6;

  typedef enum logic [2:0] {
    OpAppend     = 3'd0,
    OpSetFinal   = 3'd1,
    OpSetDelim   = 3'd2,
    OpDeliver    = 3'd3,
    OpResetFrame = 3'd4
  } opcode_e;

  typedef enum logic {
    StIdle    = 1'b0,
    StPayload = 1'b1
  } state_e;

  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] data_byte;
    logic       final_flag;
    logic [5:0] delimiter_value;
  } req_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_of_frame;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// File: hw/rtl/cfb_cell.sv
// One byte cell of the payload chain: loads an appended byte or takes its
// upstream neighbor's byte on a shift. Depends on cfb_pkg.
`default_nettype none

module cfb_cell (
  input  wire logic                clk_i,
  input  wire cfb_pkg::cell_ctrl_t ctrl_i,
  input  wire logic [7:0]          load_byte_i,
  input  wire logic [7:0]          next_byte_i,
  output logic      [7:0]          byte_o
);

  logic [7:0] byte_q;
  logic [7:0] byte_d;

  always_comb begin
    byte_d = byte_q;
    if (ctrl_i.load) begin
      byte_d = load_byte_i;
    end else if (ctrl_i.shift) begin
      byte_d = next_byte_i;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  assign byte_o = byte_q;

endmodule

`default_nettype wire

// File: hw/rtl/chunked_frame_builder_unit.sv
// Top level of the chunked frame builder: header/count registers, emission
// FSM, output register and the row of cfb_cell payload cells. Depends on
// cfb_pkg and cfb_cell.
//
// Usage:
// - Request channel (in_valid_i/in_ready_o/in_req_i) carries append, set
//   final, set delimiter, deliver and reset frame commands; opcodes 5..7 are
//   accepted and dropped.
// - Response channel (out_valid_o/out_ready_i/out_rsp_o) carries the emitted
//   frame bytes, header first, with last_of_frame on the final byte.
// - Appended bytes are written into a row of byte cells at the position of
//   the fill count. On emission the row shifts toward cell 0 once per
//   delivered payload byte, so cell 0 always holds the next byte to send.
// - A request that emits nothing completes on acceptance; requests can arrive
//   back to back at one per cycle while the output register is free.
// - A deliver, or the append that fills the frame, puts the header into the
//   output register in the cycle after acceptance and then one payload byte
//   per cycle whenever the output register is free; in_ready_o stays low
//   while the payload drains through the cell row.
// - in_ready_o also drops while the output register holds a byte the
//   receiver has not taken, so a stalled receiver simply holds the block.
// - Reset clears the header, fill count, FSM and output valid; the cell
//   contents are unknown until written and are never read before that.
`default_nettype none

module chunked_frame_builder_unit (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire cfb_pkg::req_t in_req_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output cfb_pkg::rsp_t      out_rsp_o
);

  localparam int unsigned CountW = cfb_pkg::CountW;
  localparam int unsigned Depth  = cfb_pkg::StoreDepth;

  cfb_pkg::state_e     state_q, state_d;
  logic [7:0]          hdr_q, hdr_d;
  logic [CountW-1:0]   count_q, count_d;
  logic [CountW-1:0]   rem_q, rem_d;
  logic                out_valid_q, out_valid_d;
  cfb_pkg::rsp_t       out_q, out_d;

  logic                in_fire;
  logic                out_free;
  logic [CountW-1:0]   count_inc;
  logic                frame_full;
  logic                emit;
  logic [7:0]          emit_hdr;
  logic [CountW-1:0]   emit_len;
  logic                cell_load;
  logic                cell_shift;
  cfb_pkg::cell_ctrl_t cell_ctrl [Depth];
  logic [7:0]          cell_byte [Depth];

  // Output register is free when empty or being taken this cycle.
  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == cfb_pkg::StIdle) && out_free;
  assign in_fire    = in_valid_i && in_ready_o;

  assign count_inc  = count_q + CountW'(1);
  assign frame_full = (count_inc == CountW'(Depth));

  always_comb begin
    state_d     = state_q;
    hdr_d       = hdr_q;
    count_d     = count_q;
    rem_d       = rem_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    emit        = 1'b0;
    emit_hdr    = hdr_q;
    emit_len    = count_q;
    cell_load   = 1'b0;
    cell_shift  = 1'b0;

    // Drop the valid once the receiver takes the byte; reloads below win.
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      cfb_pkg::StIdle: begin
        if (in_fire) begin
          case (cfb_pkg::opcode_e'(in_req_i.opcode))
            cfb_pkg::OpAppend: begin
              cell_load = 1'b1;
              count_d   = count_inc;
              hdr_d     = {hdr_q[7:6], cfb_pkg::HdrLenW'(count_inc)};
              if (frame_full) begin
                emit     = 1'b1;
                emit_hdr = {hdr_q[7:6], cfb_pkg::HdrLenW'(count_inc)};
                emit_len = count_inc;
              end
            end
            cfb_pkg::OpSetFinal: begin
              hdr_d[cfb_pkg::HdrFinalB] = in_req_i.final_flag;
            end
            cfb_pkg::OpSetDelim: begin
              hdr_d = {hdr_q[cfb_pkg::HdrFinalB], 1'b1, in_req_i.delimiter_value};
            end
            cfb_pkg::OpDeliver: begin
              emit = 1'b1;
            end
            cfb_pkg::OpResetFrame: begin
              hdr_d   = '0;
              count_d = '0;
            end
            default: begin
              // Unused opcode: accept and drop.
            end
          endcase

          if (emit) begin
            // A delimiter frame is the header byte alone.
            if (emit_hdr[cfb_pkg::HdrDelimB]) begin
              emit_len = '0;
            end
            hdr_d       = '0;
            count_d     = '0;
            out_d       = '{frame_byte: emit_hdr, last_of_frame: (emit_len == '0)};
            out_valid_d = 1'b1;
            if (emit_len != '0) begin
              rem_d   = emit_len;
              state_d = cfb_pkg::StPayload;
            end
          end
        end
      end
      cfb_pkg::StPayload: begin
        // Advance the chain by one byte each time the output slot frees up.
        if (out_free) begin
          cell_shift  = 1'b1;
          out_d       = '{frame_byte: cell_byte[0],
                          last_of_frame: (rem_q == CountW'(1))};
          out_valid_d = 1'b1;
          rem_d       = rem_q - CountW'(1);
          if (rem_q == CountW'(1)) begin
            state_d = cfb_pkg::StIdle;
          end
        end
      end
      default: begin
        state_d = cfb_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cfb_pkg::StIdle;
      hdr_q       <= '0;
      count_q     <= '0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      hdr_q       <= hdr_d;
      count_q     <= count_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  // Payload row: cell k loads on an append at fill position k, and takes
  // cell k+1's byte on every shift (the last cell keeps its own byte).
  for (genvar k = 0; k < Depth; k++) begin : g_cell
    logic [7:0] next_byte;

    if (k == Depth - 1) begin : g_tail
      assign next_byte = cell_byte[k];
    end else begin : g_body
      assign next_byte = cell_byte[k+1];
    end

    assign cell_ctrl[k] = '{load:  cell_load && (count_q == CountW'(k)),
                            shift: cell_shift};

    cfb_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (cell_ctrl[k]),
      .load_byte_i (in_req_i.data_byte),
      .next_byte_i (next_byte),
      .byte_o      (cell_byte[k])
    );
  end

`ifndef SYNTHESIS
  // Draining state always has bytes left to send.
  a_rem_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cfb_pkg::StPayload) |-> (rem_q != '0))
    else $error("payload drain with zero remaining bytes");

  // Fill count never reaches the store depth between requests.
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |-> (count_q < CountW'(Depth)))
    else $error("fill count out of range");

  // Loading the last payload byte returns the FSM to idle.
  a_last_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cfb_pkg::StPayload && out_free && rem_q == CountW'(1))
      |=> (state_q == cfb_pkg::StIdle && out_valid_q && out_q.last_of_frame))
    else $error("last payload byte did not end the frame");

  // No new request is taken while a frame drains.
  a_no_accept_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cfb_pkg::StPayload) |-> !in_ready_o)
    else $error("request accepted during payload drain");
`endif

endmodule

`default_nettype wire
